// ----- rtl/npe_pkg.sv -----
// Shared types and constants for the next-permutation engine.
// No dependencies; used by the front, back and top level.
`timescale 1ns / 1ps
`default_nettype none

package npe_pkg;

  // Width of the value fields on the ports.
  localparam int VALUE_WIDTH = 32;

  // Entries in the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // How the front classified one request.
  typedef struct packed {
    logic last;  // closes the sequence
    logic keep;  // element is stored (capacity not yet reached)
    logic ovf;   // an element of this sequence has been dropped so far
  } npe_flags_t;

endpackage

`default_nettype wire

// ----- rtl/npe_queue.sv -----
// Small FIFO between the front and the back of the engine.
// Generic: width and depth come from the instantiating module.
`timescale 1ns / 1ps
`default_nettype none

module npe_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNTW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNTW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/npe_front.sv -----
// Front part: accepts requests, counts elements, decides store or drop.
// Uses npe_pkg for the classification flags; feeds npe_queue.
`timescale 1ns / 1ps
`default_nettype none

module npe_front #(
  parameter int MAX_LEN    = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  valid,
  output logic                                       ready,
  input  wire logic signed [npe_pkg::VALUE_WIDTH-1:0] value,
  input  wire logic                                  last,
  output logic                                       push,
  input  wire logic                                  push_ready,
  output logic             [ELEM_WIDTH-1:0]          elem,
  output logic             [$clog2(MAX_LEN)-1:0]     addr,
  output logic             [$clog2(MAX_LEN+1)-1:0]   count_after,
  output npe_pkg::npe_flags_t                        flags
);

  localparam int IW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  logic [CW-1:0] count;
  logic          ovf;
  logic          keep;

  always_comb begin
    keep        = (count < CW'(MAX_LEN));
    ready       = push_ready;
    push        = valid && push_ready;
    // Bits above ELEM_WIDTH are ignored; narrower ports zero-extend.
    elem        = ELEM_WIDTH'($unsigned(value));
    addr        = count[IW-1:0];
    count_after = keep ? count + CW'(1) : count;
    flags.last  = last;
    flags.keep  = keep;
    flags.ovf   = ovf || !keep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (push) begin
      if (last) begin
        count <= '0;
        ovf   <= 1'b0;
      end else begin
        count <= count_after;
        ovf   <= flags.ovf;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/npe_back.sv -----
// Back part: loads elements into the store, rewrites it into the next
// permutation, and streams it out. Uses npe_pkg; fed by npe_queue.
`timescale 1ns / 1ps
`default_nettype none

module npe_back #(
  parameter int MAX_LEN    = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   q_valid,
  output logic                                        q_ready,
  input  wire logic        [ELEM_WIDTH-1:0]           q_elem,
  input  wire logic        [$clog2(MAX_LEN)-1:0]      q_addr,
  input  wire logic        [$clog2(MAX_LEN+1)-1:0]    q_count,
  input  wire npe_pkg::npe_flags_t                    q_flags,
  output logic                                        result_valid,
  input  wire logic                                   result_ready,
  output logic signed      [npe_pkg::VALUE_WIDTH-1:0] result_value,
  output logic                                        result_last,
  output logic                                        truncated
);

  localparam int IW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int VW = npe_pkg::VALUE_WIDTH;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_ASC  = 3'd1;
  localparam logic [2:0] S_SUCC = 3'd2;
  localparam logic [2:0] S_SWAP = 3'd3;
  localparam logic [2:0] S_REV  = 3'd4;
  localparam logic [2:0] S_REVL = 3'd5;
  localparam logic [2:0] S_REVH = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  // Element store, one write and two read ports, read data registered.
  logic [ELEM_WIDTH-1:0] store [MAX_LEN];
  logic [ELEM_WIDTH-1:0] qa;
  logic [ELEM_WIDTH-1:0] qb;
  logic                  re_a;
  logic                  re_b;
  logic [IW-1:0]         ra;
  logic [IW-1:0]         rb;
  logic                  we;
  logic [IW-1:0]         wa;
  logic [ELEM_WIDTH-1:0] wd;

  logic [2:0]            state, state_next;
  logic [CW-1:0]         n, n_next;
  logic                  ovf, ovf_next;
  logic [IW-1:0]         p, p_next;
  logic                  chk, chk_next;
  logic [IW-1:0]         chk_idx, chk_idx_next;
  logic [IW-1:0]         piv_i, piv_i_next;
  logic [ELEM_WIDTH-1:0] pivot, pivot_next;
  logic [IW-1:0]         j, j_next;
  logic [IW-1:0]         lo, lo_next;
  logic [IW-1:0]         hi, hi_next;
  logic [CW-1:0]         k, k_next;
  logic                  pend, pend_next;
  logic                  pend_last, pend_last_next;
  logic                  mv;
  logic                  iss;
  logic [CW-1:0]         qn_m2;
  logic [CW-1:0]         n_m1;
  logic [IW-1:0]         lo_inc;
  logic [IW-1:0]         hi_dec;

  always_comb begin
    state_next     = state;
    n_next         = n;
    ovf_next       = ovf;
    p_next         = p;
    chk_next       = chk;
    chk_idx_next   = chk_idx;
    piv_i_next     = piv_i;
    pivot_next     = pivot;
    j_next         = j;
    lo_next        = lo;
    hi_next        = hi;
    k_next         = k;
    q_ready        = 1'b0;
    re_a           = 1'b0;
    re_b           = 1'b0;
    ra             = '0;
    rb             = '0;
    we             = 1'b0;
    wa             = '0;
    wd             = '0;
    iss            = 1'b0;
    qn_m2          = q_count - CW'(2);
    n_m1           = n - CW'(1);
    lo_inc         = lo + IW'(1);
    hi_dec         = hi - IW'(1);
    mv             = pend && (!result_valid || result_ready);

    unique case (state)
      S_LOAD: begin
        q_ready = 1'b1;
        if (q_valid) begin
          if (q_flags.keep) begin
            we = 1'b1;
            wa = q_addr;
            wd = q_elem;
          end
          if (q_flags.last) begin
            n_next   = q_count;
            ovf_next = q_flags.ovf;
            if (q_count < CW'(2)) begin
              lo_next    = '0;
              hi_next    = '0;
              state_next = S_REV;
            end else begin
              p_next     = qn_m2[IW-1:0];
              chk_next   = 1'b0;
              state_next = S_ASC;
            end
          end
        end
      end

      // Walk pairs from the right; one read pair issued per cycle.
      S_ASC: begin
        re_a         = 1'b1;
        re_b         = 1'b1;
        ra           = p;
        rb           = p + IW'(1);
        chk_next     = 1'b1;
        chk_idx_next = p;
        p_next       = (p == '0) ? p : p - IW'(1);
        if (chk) begin
          if ($signed(qa) < $signed(qb)) begin
            piv_i_next = chk_idx;
            pivot_next = qa;
            p_next     = n_m1[IW-1:0];
            chk_next   = 1'b0;
            state_next = S_SUCC;
          end else if (chk_idx == '0) begin
            // No ascent: reverse the whole sequence.
            lo_next    = '0;
            hi_next    = n_m1[IW-1:0];
            state_next = S_REV;
          end
        end
      end

      // Rightmost element above the pivot; the one after it always qualifies.
      S_SUCC: begin
        re_a         = 1'b1;
        ra           = p;
        chk_next     = 1'b1;
        chk_idx_next = p;
        p_next       = (p == '0) ? p : p - IW'(1);
        if (chk && ($signed(qa) > $signed(pivot))) begin
          we         = 1'b1;
          wa         = piv_i;
          wd         = qa;
          j_next     = chk_idx;
          state_next = S_SWAP;
        end
      end

      S_SWAP: begin
        we         = 1'b1;
        wa         = j;
        wd         = pivot;
        lo_next    = piv_i + IW'(1);
        hi_next    = n_m1[IW-1:0];
        state_next = S_REV;
      end

      S_REV: begin
        if (lo < hi) begin
          re_a       = 1'b1;
          re_b       = 1'b1;
          ra         = lo;
          rb         = hi;
          state_next = S_REVL;
        end else begin
          k_next     = '0;
          state_next = S_EMIT;
        end
      end

      S_REVL: begin
        we         = 1'b1;
        wa         = lo;
        wd         = qb;
        state_next = S_REVH;
      end

      // Finish the swap and fetch the next pair in the same cycle.
      S_REVH: begin
        we      = 1'b1;
        wa      = hi;
        wd      = qa;
        lo_next = lo_inc;
        hi_next = hi_dec;
        if (lo_inc < hi_dec) begin
          re_a       = 1'b1;
          re_b       = 1'b1;
          ra         = lo_inc;
          rb         = hi_dec;
          state_next = S_REVL;
        end else begin
          k_next     = '0;
          state_next = S_EMIT;
        end
      end

      S_EMIT: begin
        iss = (k != n) && (!pend || mv);
        if (iss) begin
          re_a   = 1'b1;
          ra     = k[IW-1:0];
          k_next = k + CW'(1);
        end
        if ((k == n) && !pend) begin
          state_next = S_LOAD;
        end
      end

      default: begin
        state_next = S_LOAD;
      end
    endcase

    pend_next      = iss ? 1'b1 : (mv ? 1'b0 : pend);
    pend_last_next = iss ? ((k + CW'(1)) == n) : pend_last;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[wa] <= wd;
    end
    if (re_a) begin
      qa <= store[ra];
    end
    if (re_b) begin
      qb <= store[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      chk          <= 1'b0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      chk   <= chk_next;
      pend  <= pend_next;
      if (mv) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    n         <= n_next;
    ovf       <= ovf_next;
    p         <= p_next;
    chk_idx   <= chk_idx_next;
    piv_i     <= piv_i_next;
    pivot     <= pivot_next;
    j         <= j_next;
    lo        <= lo_next;
    hi        <= hi_next;
    k         <= k_next;
    pend_last <= pend_last_next;
    if (mv) begin
      result_value <= VW'(qa);
      result_last  <= pend_last;
      truncated    <= ovf;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/next_permutation_engine.sv -----
// Next lexicographic permutation of a sequence of up to MAX_LEN elements.
// Loading accepts one element per cycle while the queue has room. After the closing
// request the back part runs the ascent search, then, if an ascent is found, the
// successor search and the swap, then the reversal and the output; it takes no new
// element until the last result has gone to the output register.
// Reset clears control state only; the element store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module next_permutation_engine #(
  parameter int MAX_LEN    = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   valid,
  output logic                                        ready,
  input  wire logic signed [npe_pkg::VALUE_WIDTH-1:0] value,
  input  wire logic                                   last,
  output logic                                        result_valid,
  input  wire logic                                   result_ready,
  output logic signed      [npe_pkg::VALUE_WIDTH-1:0] result_value,
  output logic                                        result_last,
  output logic                                        truncated
);

  localparam int IW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int FW = $bits(npe_pkg::npe_flags_t);
  localparam int QW = ELEM_WIDTH + IW + CW + FW;

  logic                  f_push;
  logic                  f_push_ready;
  logic [ELEM_WIDTH-1:0] f_elem;
  logic [IW-1:0]         f_addr;
  logic [CW-1:0]         f_count;
  npe_pkg::npe_flags_t   f_flags;

  logic                  q_valid;
  logic                  q_ready;
  logic [QW-1:0]         q_data;
  logic [ELEM_WIDTH-1:0] q_elem;
  logic [IW-1:0]         q_addr;
  logic [CW-1:0]         q_count;
  npe_pkg::npe_flags_t   q_flags;

  npe_front #(
    .MAX_LEN    (MAX_LEN),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .valid       (valid),
    .ready       (ready),
    .value       (value),
    .last        (last),
    .push        (f_push),
    .push_ready  (f_push_ready),
    .elem        (f_elem),
    .addr        (f_addr),
    .count_after (f_count),
    .flags       (f_flags)
  );

  npe_queue #(
    .WIDTH (QW),
    .DEPTH (npe_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_push),
    .push_ready (f_push_ready),
    .push_data  ({f_elem, f_addr, f_count, f_flags}),
    .pop_valid  (q_valid),
    .pop        (q_ready),
    .pop_data   (q_data)
  );

  assign {q_elem, q_addr, q_count, q_flags} = q_data;

  npe_back #(
    .MAX_LEN    (MAX_LEN),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_elem       (q_elem),
    .q_addr       (q_addr),
    .q_count      (q_count),
    .q_flags      (q_flags),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_value (result_value),
    .result_last  (result_last),
    .truncated    (truncated)
  );

endmodule

`default_nettype wire
